// ----- rtl/core/sec_pkg.sv -----
// Package for the synaptic event conductance channel.
// Holds widths, defaults, register indexes, the beat payload types and the
// saturating helper sat32. No dependencies.
package sec_pkg;

  localparam int unsigned QueueDepthDefault = 64;
  localparam int unsigned FracBitsDefault   = 16;
  localparam int unsigned DataW             = 32;
  localparam int unsigned CountW            = 7;
  localparam int unsigned CfgIdxW           = 3;
  localparam int unsigned InvDtW            = 31;

  localparam logic [CfgIdxW-1:0] RegXGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXDecay = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegYDecay = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNorm   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvDt  = 3'd5;

  localparam logic OpPush = 1'b0;
  localparam logic OpTick = 1'b1;

  // Payload of one input beat.
  typedef struct packed {
    logic                    operation;
    logic [DataW-1:0]        event_time;
    logic signed [DataW-1:0] event_weight;
    logic [DataW-1:0]        current_time;
    logic signed [DataW-1:0] external_activation;
    logic signed [DataW-1:0] modulation;
  } sec_in_t;

  // Payload of one result beat.
  typedef struct packed {
    logic signed [DataW-1:0] conductance;
    logic                    event_dropped;
    logic [CountW-1:0]       pending_count;
  } sec_out_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [79:0] v);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = 80'sd2147483647;
    lo = -80'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[DataW-1:0];
  endfunction

endpackage

// ----- rtl/core/sec_stream_if.sv -----
// Valid/ready channel interface for the conductance channel.
// Depends on nothing; the payload type is a parameter.
interface sec_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/synaptic_event_conductance.sv -----
// Top level of the synaptic event conductance channel.
// Depends on sec_pkg, sec_stream_if, sec_queue and sec_stages.
//
// A push beat stores an event in the queue memory (or flags it dropped when
// the queue is full). A tick beat scans the stored events once through a
// registered-read memory, one entry per cycle, summing weight * inv_dt of
// due events and compacting the rest in place; it then runs nine steps on
// one shared 32x32 multiplier for the modulation, the two stages and the
// normalization. One beat is worked at a time; the result waits in an output
// register, and the next input beat is taken once that result has gone.
module synaptic_event_conductance #(
  parameter int unsigned QueueDepth = sec_pkg::QueueDepthDefault,
  parameter int unsigned FracBits   = sec_pkg::FracBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sec_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [sec_pkg::DataW-1:0]           cfg_data_i,
  sec_stream_if.sink                          in_if,
  sec_stream_if.source                        out_if
);
  import sec_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {TIdle, TPush, TScan, TWaitScan, TStage, TOut} top_state_e;

  top_state_e state_q;
  logic signed [DataW-1:0] xg_q, xd_q, yg_q, yd_q, norm_q;
  logic [InvDtW-1:0]       inv_dt_q;
  logic                    op_q;
  logic [DataW-1:0]        etime_q, now_q;
  logic signed [DataW-1:0] ewt_q, ext_q, mod_q;
  logic signed [DataW-1:0] cond_o_q;
  logic                    drop_q;
  logic                    oval_q;

  logic push, scan, q_busy, q_full, st_done;
  logic signed [79:0] q_sum;
  logic [CntW-1:0] q_count;
  logic signed [DataW-1:0] st_cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xg_q <= '0; xd_q <= '0; yg_q <= '0; yd_q <= '0;
      norm_q <= 32'sd1 <<< FracBits;
      inv_dt_q <= InvDtW'(1) << FracBits;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegXGain:  xg_q <= cfg_data_i;
        RegXDecay: xd_q <= cfg_data_i;
        RegYGain:  yg_q <= cfg_data_i;
        RegYDecay: yd_q <= cfg_data_i;
        RegNorm:   norm_q <= cfg_data_i;
        RegInvDt:  inv_dt_q <= cfg_data_i[InvDtW-1:0];
        default: ;
      endcase
    end
  end

  // Input is only taken when idle and the previous result has left.
  assign in_if.ready = (state_q == TIdle) && !oval_q;
  assign push = (state_q == TPush) && (op_q == OpPush);
  assign scan = (state_q == TPush) && (op_q == OpTick);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TIdle;
      oval_q  <= 1'b0;
      drop_q  <= 1'b0;
      cond_o_q <= '0;
      op_q    <= OpPush;
      etime_q <= '0;
      ewt_q   <= '0;
      now_q   <= '0;
      ext_q   <= '0;
      mod_q   <= '0;
    end else begin
      if (state_q == TOut) oval_q <= 1'b1;
      else if (out_if.valid && out_if.ready) oval_q <= 1'b0;
      unique case (state_q)
        TIdle: if (in_if.valid && !oval_q) begin
          op_q    <= in_if.data.operation;
          etime_q <= in_if.data.event_time;
          ewt_q   <= in_if.data.event_weight;
          now_q   <= in_if.data.current_time;
          ext_q   <= in_if.data.external_activation;
          mod_q   <= in_if.data.modulation;
          state_q <= TPush;
        end
        TPush: begin
          drop_q  <= (op_q == OpPush) && q_full;
          state_q <= (op_q == OpPush) ? TOut : TScan;
        end
        TScan: state_q <= TWaitScan;
        TWaitScan: if (!q_busy) state_q <= TStage;
        TStage: if (st_done) begin
          cond_o_q <= st_cond;
          state_q  <= TOut;
        end
        TOut: state_q <= TIdle;
        default: state_q <= TIdle;
      endcase
    end
  end

  sec_queue #(.QueueDepth(QueueDepth), .FracBits(FracBits)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_time_i(etime_q), .push_weight_i(ewt_q),
    .scan_i(scan), .now_i(now_q), .inv_dt_i(inv_dt_q),
    .busy_o(q_busy), .full_o(q_full), .sum_o(q_sum), .count_o(q_count)
  );

  sec_stages #(.FracBits(FracBits)) u_stages (
    .clk_i, .rst_ni,
    .start_i((state_q == TWaitScan) && !q_busy),
    .acc_i(q_sum + 80'(ext_q)), .mod_i(mod_q),
    .xg_i(xg_q), .xd_i(xd_q), .yg_i(yg_q), .yd_i(yd_q), .norm_i(norm_q),
    .done_o(st_done), .cond_o(st_cond)
  );

  assign out_if.valid = oval_q;
  assign out_if.data.conductance   = cond_o_q;
  assign out_if.data.event_dropped = drop_q;
  assign out_if.data.pending_count = CountW'(q_count);

  // A new beat is never taken while a result still waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> !oval_q)
    else $error("input taken over pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == TOut |=> oval_q)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == TStage) |-> !q_busy)
    else $error("stages started before scan end");
endmodule

// ----- rtl/core/sec_queue.sv -----
// Event queue memory with a scan and compaction pass for ticks.
// Depends on sec_pkg.
module sec_queue #(
  parameter int unsigned QueueDepth = sec_pkg::QueueDepthDefault,
  parameter int unsigned FracBits   = sec_pkg::FracBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [sec_pkg::DataW-1:0]       push_time_i,
  input  logic signed [sec_pkg::DataW-1:0] push_weight_i,
  input  logic                            scan_i,
  input  logic [sec_pkg::DataW-1:0]       now_i,
  input  logic [sec_pkg::InvDtW-1:0]      inv_dt_i,
  output logic                            busy_o,
  output logic                            full_o,
  output logic signed [79:0]              sum_o,
  output logic [$clog2(QueueDepth+1)-1:0] count_o
);
  import sec_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic [DataW-1:0]        time_mem [QueueDepth];
  logic signed [DataW-1:0] wt_mem   [QueueDepth];

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic            scanning_q, scanning_d;
  logic            rvalid_q, rvalid_d;
  logic            mul_v_q;
  logic [DataW-1:0]        rtime_q;
  logic signed [DataW-1:0] rwt_q;
  logic signed [63:0]      prod_q;
  logic signed [79:0]      sum_q;

  logic               due;
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic [DataW-1:0]   wr_time;
  logic signed [DataW-1:0] wr_wt;
  logic signed [63:0] sh;

  assign due = rtime_q <= now_i;
  assign sh  = prod_q >>> FracBits;

  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    kept_d     = kept_q;
    scanning_d = scanning_q;
    rvalid_d   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = count_q[AddrW-1:0];
    wr_time    = push_time_i;
    wr_wt      = push_weight_i;
    if (push_i && (count_q < CntW'(QueueDepth))) begin
      wr_en   = 1'b1;
      count_d = count_q + 1'b1;
    end
    if (scan_i) begin
      scanning_d = 1'b1;
      rd_d       = '0;
      kept_d     = '0;
    end else if (scanning_q) begin
      if (rd_q < count_q) begin
        rvalid_d = 1'b1;
        rd_d     = rd_q + 1'b1;
      end else if (!rvalid_q && !mul_v_q) begin
        scanning_d = 1'b0;
        count_d    = kept_q;
      end
      if (rvalid_q && !due) begin
        wr_en   = 1'b1;
        wr_addr = kept_q[AddrW-1:0];
        wr_time = rtime_q;
        wr_wt   = rwt_q;
        kept_d  = kept_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_q       <= '0;
      kept_q     <= '0;
      scanning_q <= 1'b0;
      rvalid_q   <= 1'b0;
      mul_v_q    <= 1'b0;
    end else begin
      count_q    <= count_d;
      rd_q       <= rd_d;
      kept_q     <= kept_d;
      scanning_q <= scanning_d;
      rvalid_q   <= rvalid_d;
      mul_v_q    <= rvalid_q && due;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      wt_mem[wr_addr]   <= wr_wt;
    end
    rtime_q <= time_mem[rd_q[AddrW-1:0]];
    rwt_q   <= wt_mem[rd_q[AddrW-1:0]];
    prod_q  <= 64'(rwt_q) * $signed({1'b0, inv_dt_i});
    if (scan_i) sum_q <= '0;
    else if (mul_v_q) sum_q <= sum_q + 80'(sh);
  end

  assign busy_o  = scanning_q;
  assign full_o  = count_q == CntW'(QueueDepth);
  assign sum_o   = sum_q;
  assign count_o = count_q;

  // Compaction never writes ahead of the read pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) scanning_q |-> kept_q <= rd_q)
    else $error("queue compaction overtook scan");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(QueueDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) scanning_q |-> !push_i)
    else $error("push during scan");
endmodule

// ----- rtl/core/sec_stages.sv -----
// Sequenced multiply datapath for modulation, the two filter stages and conductance.
// Depends on sec_pkg.
module sec_stages #(
  parameter int unsigned FracBits = sec_pkg::FracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [79:0]               acc_i,
  input  logic signed [sec_pkg::DataW-1:0] mod_i,
  input  logic signed [sec_pkg::DataW-1:0] xg_i,
  input  logic signed [sec_pkg::DataW-1:0] xd_i,
  input  logic signed [sec_pkg::DataW-1:0] yg_i,
  input  logic signed [sec_pkg::DataW-1:0] yd_i,
  input  logic signed [sec_pkg::DataW-1:0] norm_i,
  output logic                             done_o,
  output logic signed [sec_pkg::DataW-1:0] cond_o
);
  import sec_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SMod, SXin, SXdec, SXsum, SYin, SYdec, SYsum, SNorm, SDone
  } state_e;

  state_e state_q;
  logic signed [DataW-1:0] x_q, y_q, c_q, act_q, m_q, t_q;
  logic signed [DataW-1:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [DataW-1:0] q;

  always_comb begin
    unique case (state_q)
      SMod:    begin ma = mod_i; mb = act_q; end
      SXin:    begin ma = m_q;   mb = xg_i;  end
      SXdec:   begin ma = x_q;   mb = xd_i;  end
      SYin:    begin ma = x_q;   mb = yg_i;  end
      SYdec:   begin ma = y_q;   mb = yd_i;  end
      SNorm:   begin ma = y_q;   mb = norm_i; end
      default: begin ma = '0;    mb = '0;    end
    endcase
    prod = 64'(ma) * 64'(mb);
    q    = sat32(80'(prod >>> FracBits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      x_q <= '0; y_q <= '0; c_q <= '0;
      act_q <= '0; m_q <= '0; t_q <= '0;
    end else begin
      unique case (state_q)
        SIdle: if (start_i) begin
          act_q   <= sat32(acc_i);
          state_q <= SMod;
        end
        SMod:  begin m_q <= q; state_q <= SXin; end
        SXin:  begin t_q <= q; state_q <= SXdec; end
        SXdec: begin m_q <= q; state_q <= SXsum; end
        SXsum: begin x_q <= sat32(80'(t_q) + 80'(m_q)); state_q <= SYin; end
        SYin:  begin t_q <= q; state_q <= SYdec; end
        SYdec: begin m_q <= q; state_q <= SYsum; end
        SYsum: begin y_q <= sat32(80'(t_q) + 80'(m_q)); state_q <= SNorm; end
        SNorm: begin c_q <= q; state_q <= SDone; end
        SDone: state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  assign done_o = state_q == SDone;
  assign cond_o = c_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) state_q == SNorm |=> done_o)
    else $error("stage sequence skipped done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> state_q == SIdle)
    else $error("stage sequence did not return");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !start_i)
    else $error("stage start while busy");
endmodule
